/* src/scfr_pkg.sv */
package scfr_pkg;

  localparam int DEF_FRAME_BYTES = 512;
  localparam int DEF_MAX_SERVOS  = 32;

  localparam int IDX_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] HEADER_BYTE    = 8'h55;
  localparam logic [7:0] FRAME_LEN_MIN  = 8'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_SERVO_MOVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_ACTION_RUN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_ACTION_STOP = 2'd2;

  typedef enum logic [1:0] {
    KIND_SERVO_MOVE  = 2'd0,
    KIND_ACTION_RUN  = 2'd1,
    KIND_ACTION_STOP = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] servo_move;
    logic [7:0] action_run;
    logic [7:0] action_stop;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [7:0] len;
  } dec_req_t;

endpackage

/* src/scfr_buffer.sv */
module scfr_buffer #(
  parameter int FRAME_BYTES = 512
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  input  logic [7:0]                     wr_data,
  input  logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
  output logic [7:0]                     rd_data
);

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/scfr_decoder.sv */
module scfr_decoder #(
  parameter int MAX_SERVOS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scfr_pkg::cfg_t        cfg,
  input  scfr_pkg::dec_req_t    req,
  output logic                  busy,
  output logic [scfr_pkg::IDX_W-1:0] rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_result_kind,
  output logic [7:0]            out_servo_id,
  output logic [15:0]           out_servo_position,
  output logic [15:0]           out_move_time,
  output logic [7:0]            out_action_group,
  output logic [15:0]           out_run_count,
  output logic                  out_last
);

  import scfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_SERVOS + 1);

  localparam logic [IDX_W-1:0] ADDR_CMD   = 9'd3;
  localparam logic [IDX_W-1:0] ADDR_COUNT = 9'd4;
  localparam logic [IDX_W-1:0] ADDR_WLO   = 9'd5;
  localparam logic [IDX_W-1:0] ADDR_WHI   = 9'd6;
  localparam logic [IDX_W-1:0] ADDR_ENTRY = 9'd7;
  localparam logic [IDX_W-1:0] ENTRY_STEP = 9'd3;
  localparam logic [7:0]       LEN_ONE_ENTRY = 8'd8;

  typedef enum logic [3:0] {
    S_IDLE, S_A3, S_A4, S_A5, S_A6, S_CHK, S_E0, S_E1, S_E2, S_E3, S_PUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        b4_r, b4_nxt;
  logic [7:0]        b5_r, b5_nxt;
  logic [15:0]       time_r, time_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  kind_t             kind_r, kind_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [15:0]       pos_r, pos_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              ov_r, ov_nxt;
  logic [1:0]        okind_r, okind_nxt;
  logic [7:0]        oid_r, oid_nxt;
  logic [15:0]       opos_r, opos_nxt;
  logic [15:0]       otime_r, otime_nxt;
  logic [7:0]        ogrp_r, ogrp_nxt;
  logic [15:0]       ocnt_r, ocnt_nxt;
  logic              olast_r, olast_nxt;

  logic [7:0]        byte_v;
  logic              out_free;
  logic              emit;
  logic [15:0]       e_pos;
  logic              next_fits;
  logic              last_entry;
  logic              is_move;
  logic              is_run;
  logic              is_stop;
  logic [CNT_W-1:0]  cnt_lim;

  always_comb begin
    case (state_r)
      S_A3:    rd_addr = ADDR_CMD;
      S_A4:    rd_addr = ADDR_COUNT;
      S_A5:    rd_addr = ADDR_WLO;
      S_A6:    rd_addr = ADDR_WHI;
      S_E0:    rd_addr = base_r;
      S_E1:    rd_addr = base_r + 9'd1;
      S_E2:    rd_addr = base_r + 9'd2;
      default: rd_addr = '0;
    endcase
  end

  // bytes beyond the end of the frame read as zero
  assign rd_ok_nxt = ({1'b0, rd_addr} <= ({2'b00, len_r} + 10'd1));
  assign byte_v    = rd_ok_r ? rd_data : 8'd0;

  assign out_free   = !ov_r || !out_stall;
  assign e_pos      = (state_r == S_E3) ? {byte_v, pos_r[7:0]} : pos_r;
  assign next_fits  = (({1'b0, base_r} + 10'd5) <= ({2'b00, len_r} + 10'd1));
  assign last_entry = ((idx_r + CNT_W'(1)) == cnt_r) || !next_fits;
  assign emit       = out_free && ((state_r == S_E3) || (state_r == S_PUT));

  assign is_move = (cmd_r == cfg.servo_move);
  assign is_run  = !is_move && (cmd_r == cfg.action_run);
  assign is_stop = !is_move && !is_run && (cmd_r == cfg.action_stop);
  assign cnt_lim = (b4_r > 8'(MAX_SERVOS)) ? CNT_W'(MAX_SERVOS) : CNT_W'(b4_r);

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    b4_nxt    = b4_r;
    b5_nxt    = b5_r;
    time_nxt  = time_r;
    base_nxt  = base_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    id_nxt    = id_r;
    pos_nxt   = pos_r;
    ov_nxt    = ov_r && out_stall;
    okind_nxt = okind_r;
    oid_nxt   = oid_r;
    opos_nxt  = opos_r;
    otime_nxt = otime_r;
    ogrp_nxt  = ogrp_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;

    case (state_r)
      S_IDLE: begin
        if (req.start) begin
          len_nxt   = req.len;
          state_nxt = S_A3;
        end
      end
      S_A3: state_nxt = S_A4;
      S_A4: begin
        cmd_nxt   = byte_v;
        state_nxt = S_A5;
      end
      S_A5: begin
        b4_nxt    = byte_v;
        state_nxt = S_A6;
      end
      S_A6: begin
        b5_nxt    = byte_v;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        time_nxt = {byte_v, b5_r};
        if (is_move) begin
          kind_nxt = KIND_SERVO_MOVE;
          base_nxt = ADDR_ENTRY;
          idx_nxt  = '0;
          cnt_nxt  = cnt_lim;
          if ((cnt_lim != '0) && (len_r >= LEN_ONE_ENTRY)) begin
            state_nxt = S_E0;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (is_run) begin
          kind_nxt  = KIND_ACTION_RUN;
          state_nxt = S_PUT;
        end else if (is_stop) begin
          kind_nxt  = KIND_ACTION_STOP;
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_E0: state_nxt = S_E1;
      S_E1: begin
        id_nxt    = byte_v;
        state_nxt = S_E2;
      end
      S_E2: begin
        pos_nxt   = {pos_r[15:8], byte_v};
        state_nxt = S_E3;
      end
      S_E3: begin
        pos_nxt = e_pos;
        if (!out_free) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: ;
      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      ov_nxt    = 1'b1;
      okind_nxt = kind_r;
      oid_nxt   = 8'd0;
      opos_nxt  = 16'd0;
      otime_nxt = 16'd0;
      ogrp_nxt  = 8'd0;
      ocnt_nxt  = 16'd0;
      olast_nxt = 1'b1;
      state_nxt = S_IDLE;
      case (kind_r)
        KIND_SERVO_MOVE: begin
          oid_nxt   = id_r;
          opos_nxt  = e_pos;
          otime_nxt = time_r;
          olast_nxt = last_entry;
          if (!last_entry) begin
            base_nxt  = base_r + ENTRY_STEP;
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_E0;
          end
        end
        KIND_ACTION_RUN: begin
          ogrp_nxt = b4_r;
          ocnt_nxt = time_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
    len_r   <= len_nxt;
    cmd_r   <= cmd_nxt;
    b4_r    <= b4_nxt;
    b5_r    <= b5_nxt;
    time_r  <= time_nxt;
    base_r  <= base_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    kind_r  <= kind_nxt;
    id_r    <= id_nxt;
    pos_r   <= pos_nxt;
    okind_r <= okind_nxt;
    oid_r   <= oid_nxt;
    opos_r  <= opos_nxt;
    otime_r <= otime_nxt;
    ogrp_r  <= ogrp_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = ov_r;
  assign out_result_kind    = okind_r;
  assign out_servo_id       = oid_r;
  assign out_servo_position = opos_r;
  assign out_move_time      = otime_r;
  assign out_action_group   = ogrp_r;
  assign out_run_count      = ocnt_r;
  assign out_last           = olast_r;

endmodule

/* src/servo_command_frame_receiver.sv */
// Receives serial bytes one transaction at a time, hunts for two 0x55 header bytes and stores
// the frame in an on-chip byte buffer. The byte after the headers is the length L (below 2
// aborts the frame); the frame closes after L+2 bytes and its command is then decoded from
// the buffer. A multi-servo move gives one result per servo entry, action run and action
// stop give one result each, unknown commands give none; out_last marks the final result of
// a frame. Ordinary bytes are taken one per cycle. After the closing byte the input is held
// stalled while the decoder walks the buffer through its single read port: it reads the
// command fields (states A3 to A6 and CHK), then emits one result for an action run or stop,
// or reads three bytes per servo entry (states E0 to E3), and it stays busy longer while the
// output is stalled. No clearing pass after reset is needed.
module servo_command_frame_receiver #(
  parameter int FRAME_BYTES = scfr_pkg::DEF_FRAME_BYTES,
  parameter int MAX_SERVOS  = scfr_pkg::DEF_MAX_SERVOS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [scfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_result_kind,
  output logic [7:0]                       out_servo_id,
  output logic [15:0]                      out_servo_position,
  output logic [15:0]                      out_move_time,
  output logic [7:0]                       out_action_group,
  output logic [15:0]                      out_run_count,
  output logic                             out_last
);

  import scfr_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] IDX_FIRST = 9'd1;
  localparam logic [IDX_W-1:0] IDX_LEN   = 9'd2;

  cfg_t             cfg_r, cfg_nxt;
  logic [1:0]       header_count_r, header_count_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]       frame_length_r, frame_length_nxt;

  logic             in_acc;
  logic             frame_on;
  logic [IDX_W-1:0] idx_eff;
  logic [IDX_W-1:0] idx_inc;
  logic             aborted;
  logic             frame_done;
  logic             dec_busy;
  dec_req_t         dec_req;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = dec_busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CODE_SERVO_MOVE:  cfg_nxt.servo_move  = cfg_data;
        REG_CODE_ACTION_RUN:  cfg_nxt.action_run  = cfg_data;
        REG_CODE_ACTION_STOP: cfg_nxt.action_stop = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    header_count_nxt = header_count_r;
    in_frame_nxt     = in_frame_r;
    byte_index_nxt   = byte_index_r;
    frame_length_nxt = frame_length_r;
    frame_on         = in_frame_r;
    idx_eff          = byte_index_r;
    idx_inc          = byte_index_r + 9'd1;
    aborted          = 1'b0;
    frame_done       = 1'b0;
    if (in_acc) begin
      if (!in_frame_r) begin
        if (in_rx_byte == HEADER_BYTE) begin
          if (header_count_r == 2'd1) begin
            header_count_nxt = 2'd0;
            frame_on         = 1'b1;
            idx_eff          = IDX_FIRST;
          end else begin
            header_count_nxt = header_count_r + 2'd1;
          end
        end else begin
          header_count_nxt = 2'd0;
          byte_index_nxt   = '0;
        end
      end
      if (frame_on) begin
        if (idx_eff == IDX_LEN) begin
          if (in_rx_byte < FRAME_LEN_MIN) begin
            frame_length_nxt = FRAME_LEN_MIN;
            aborted          = 1'b1;
          end else begin
            frame_length_nxt = in_rx_byte;
          end
        end
        idx_inc        = idx_eff + 9'd1;
        byte_index_nxt = idx_inc;
        frame_done     = !aborted &&
                         ({1'b0, idx_inc} == ({2'b00, frame_length_nxt} + 10'd2));
        in_frame_nxt   = !aborted && !frame_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_move  <= 8'd3;
      cfg_r.action_run  <= 8'd6;
      cfg_r.action_stop <= 8'd7;
      header_count_r    <= 2'd0;
      in_frame_r        <= 1'b0;
      byte_index_r      <= '0;
      frame_length_r    <= FRAME_LEN_MIN;
    end else begin
      cfg_r          <= cfg_nxt;
      header_count_r <= header_count_nxt;
      in_frame_r     <= in_frame_nxt;
      byte_index_r   <= byte_index_nxt;
      frame_length_r <= frame_length_nxt;
    end
  end

  assign dec_req.start = frame_done;
  assign dec_req.len   = frame_length_r;

  scfr_buffer #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (in_acc && frame_on),
    .wr_addr (AW'(idx_eff)),
    .wr_data (in_rx_byte),
    .rd_addr (AW'(rd_addr)),
    .rd_data (rd_data)
  );

  scfr_decoder #(
    .MAX_SERVOS (MAX_SERVOS)
  ) u_decoder (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .req                (dec_req),
    .busy               (dec_busy),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_servo_id       (out_servo_id),
    .out_servo_position (out_servo_position),
    .out_move_time      (out_move_time),
    .out_action_group   (out_action_group),
    .out_run_count      (out_run_count),
    .out_last           (out_last)
  );

  a_frame_done_starts_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_done) |=> dec_busy)
    else $error("closing byte did not start the decoder");

  a_header_count_clear_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (header_count_r == 2'd0))
    else $error("header count left set inside a frame");

  a_index_within_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> ({1'b0, byte_index_r} <= ({2'b00, frame_length_r} + 10'd1)))
    else $error("byte index ran past the frame end");

endmodule
